// ===== rtl/prrt_pkg.sv =====
// ----------------------------------------------------------------------------
// prrt_pkg
// Shared types and constants for the pending request round-trip table.
// ----------------------------------------------------------------------------
package prrt_pkg;

    localparam int SEQ_W  = 32;
    localparam int TIME_W = 63;
    localparam int RTT_W  = 64;

    typedef struct packed {
        logic              pending;
        logic [SEQ_W-1:0]  sequence_req;
        logic [TIME_W-1:0] send_time;
    } slot_t;

    localparam int SLOT_W = $bits(slot_t);

    typedef struct packed {
        logic             hit;
        logic [RTT_W-1:0] round_trip_us;
    } match_res_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    localparam logic OP_RECORD = 1'b0;
    localparam logic OP_MATCH  = 1'b1;

endpackage

// ===== rtl/pending_request_rtt_table.sv =====
// ----------------------------------------------------------------------------
// pending_request_rtt_table
// Ring of request slots; records sent requests and matches acknowledgements,
// returning found flag and round-trip time.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                                  | tuser
//  s_      | in  | [31:0] sequence_req, [94:32] time_us   | operation
//  m_      | out | [63:0] round_trip_us (signed)          | found
//
//  Record word: written into the slot at the ring write pointer, no result.
//  Match word: linear scan of the slot RAM, one slot per cycle through the
//  registered read port, ending at the lowest pending slot with that sequence.
//  After reset a clearing pass writes every slot, with s_tready low.
//  A stalled result holds in the output register; records are still taken.
// ----------------------------------------------------------------------------
module pending_request_rtt_table
    import prrt_pkg::*;
#(
    parameter int SLOT_COUNT = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // sequence_req, time_us, zero pad
    input  logic        s_tuser,   // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // round_trip_us
    output logic        m_tuser    // found
);

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W = $clog2(SLOT_COUNT + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);
    localparam logic [CNT_W-1:0] SLOT_CNT = CNT_W'(SLOT_COUNT);

    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  wptr_reg, wptr_next;
    logic [IDX_W-1:0]  clr_reg, clr_next;
    logic [CNT_W-1:0]  issue_reg, issue_next;
    logic              chk_valid_reg, chk_valid_next;
    logic [IDX_W-1:0]  chk_idx_reg, chk_idx_next;
    logic [SEQ_W-1:0]  key_seq_reg, key_seq_next;
    logic [TIME_W-1:0] key_time_reg, key_time_next;
    logic              found_reg, found_next;
    logic [RTT_W-1:0]  rtt_reg, rtt_next;
    logic              m_valid_reg, m_valid_next;
    logic              m_found_reg, m_found_next;
    logic [RTT_W-1:0]  m_rtt_reg, m_rtt_next;

    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    slot_t             wr_slot;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic [SLOT_W-1:0] rd_data;
    slot_t             rd_slot;
    match_res_t        mres;
    logic              s_fire;
    logic [SEQ_W-1:0]  in_seq;
    logic [TIME_W-1:0] in_time;

    assign in_seq  = s_tdata[SEQ_W-1:0];
    assign in_time = s_tdata[SEQ_W+TIME_W-1:SEQ_W];
    assign rd_slot = slot_t'(rd_data);

    prrt_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (SLOT_COUNT),
        .ADDR_W(IDX_W)
    ) u_ram (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(SLOT_W'(wr_slot)),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    prrt_match_unit u_match (
        .slot    (rd_slot),
        .key_seq (key_seq_reg),
        .cur_time(key_time_reg),
        .res     (mres)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            wptr_reg      <= '0;
            clr_reg       <= '0;
            issue_reg     <= '0;
            chk_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            wptr_reg      <= wptr_next;
            clr_reg       <= clr_next;
            issue_reg     <= issue_next;
            chk_valid_reg <= chk_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        chk_idx_reg  <= chk_idx_next;
        key_seq_reg  <= key_seq_next;
        key_time_reg <= key_time_next;
        found_reg    <= found_next;
        rtt_reg      <= rtt_next;
        m_found_reg  <= m_found_next;
        m_rtt_reg    <= m_rtt_next;
    end

    always_comb begin
        state_next     = state_reg;
        wptr_next      = wptr_reg;
        clr_next       = clr_reg;
        issue_next     = issue_reg;
        chk_valid_next = 1'b0;
        chk_idx_next   = chk_idx_reg;
        key_seq_next   = key_seq_reg;
        key_time_next  = key_time_reg;
        found_next     = found_reg;
        rtt_next       = rtt_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_found_next   = m_found_reg;
        m_rtt_next     = m_rtt_reg;

        s_tready = 1'b0;
        s_fire   = 1'b0;
        wr_en    = 1'b0;
        wr_addr  = clr_reg;
        wr_slot  = '0;
        rd_en    = 1'b0;
        rd_addr  = issue_reg[IDX_W-1:0];

        unique case (state_reg)
            ST_CLEAR: begin
                wr_en    = 1'b1;
                clr_next = clr_reg + IDX_W'(1);
                if (clr_reg == LAST_IDX) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                s_fire   = s_tvalid;
                if (s_fire) begin
                    if (s_tuser == OP_RECORD) begin
                        wr_en                = 1'b1;
                        wr_addr              = wptr_reg;
                        wr_slot.pending      = 1'b1;
                        wr_slot.sequence_req = in_seq;
                        wr_slot.send_time    = in_time;
                        wptr_next = (wptr_reg == LAST_IDX) ? '0 : wptr_reg + IDX_W'(1);
                    end else begin
                        key_seq_next  = in_seq;
                        key_time_next = in_time;
                        issue_next    = '0;
                        state_next    = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                rd_en = issue_reg < SLOT_CNT;
                if (rd_en) begin
                    issue_next     = issue_reg + CNT_W'(1);
                    chk_valid_next = 1'b1;
                    chk_idx_next   = rd_addr;
                end
                if (chk_valid_reg) begin
                    if (mres.hit) begin
                        wr_en           = 1'b1;
                        wr_addr         = chk_idx_reg;
                        wr_slot         = rd_slot;
                        wr_slot.pending = 1'b0;
                        found_next      = 1'b1;
                        rtt_next        = mres.round_trip_us;
                        chk_valid_next  = 1'b0;
                        state_next      = ST_DONE;
                    end else if (chk_idx_reg == LAST_IDX) begin
                        found_next     = 1'b0;
                        rtt_next       = '0;
                        chk_valid_next = 1'b0;
                        state_next     = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_found_next = found_reg;
                    m_rtt_next   = rtt_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_found_reg;
    assign m_tdata  = m_rtt_reg;

endmodule

// ===== rtl/prrt_ram.sv =====
// ----------------------------------------------------------------------------
// prrt_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module prrt_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/prrt_match_unit.sv =====
// ----------------------------------------------------------------------------
// prrt_match_unit
// Shared compare and subtract: tests one slot word against the search key
// and forms the round-trip time from the stored send time.
// ----------------------------------------------------------------------------
module prrt_match_unit
    import prrt_pkg::*;
(
    input  slot_t             slot,
    input  logic [SEQ_W-1:0]  key_seq,
    input  logic [TIME_W-1:0] cur_time,
    output match_res_t        res
);

    always_comb begin
        res.hit           = slot.pending && (slot.sequence_req == key_seq);
        res.round_trip_us = {1'b0, cur_time} - {1'b0, slot.send_time};
    end

endmodule

// ===== rtl/prrt_checker.sv =====
// ----------------------------------------------------------------------------
// prrt_checker
// Port-level checks for the pending request round-trip table.
// ----------------------------------------------------------------------------
module prrt_checker
    import prrt_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic        m_tuser
);

    // stalled result word holds
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // miss carries zero time
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == 64'd0)
        else $error("miss result with nonzero round trip");

    // a match word starts a scan, input closed next cycle
    a_scan_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == OP_MATCH) |=> !s_tready)
        else $error("input open right after match word");

    // reset leaves no result and runs the clearing pass
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_tready && !m_tvalid)
        else $error("block not quiet after reset");

endmodule

bind pending_request_rtt_table prrt_checker u_prrt_checker (.*);
